@@ rtl/unwind_instruction_stream_parser_top_macros.svh @@
// Assertion macros for the cleanup program parser checker.
// No dependencies; included by the checker file.
`ifndef UNWIND_INSTRUCTION_STREAM_PARSER_TOP_MACROS_SVH
`define UNWIND_INSTRUCTION_STREAM_PARSER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UISP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("parser check failed");

// Next-cycle implication, disabled during reset.
`define UISP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("parser check failed");

`endif

@@ rtl/uisp_pkg.sv @@
// Types, codes and the per-opcode field plan of the cleanup program parser.
// No dependencies.
package uisp_pkg;

  localparam logic [4:0] OPC_MASK_W = 5'h1f;
  localparam logic [4:0] OPC_CONT   = 5'd1;
  localparam logic [4:0] OPC_TABLE  = 5'd15;
  localparam int unsigned PLAN_STEPS = 7;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_OPCODE      = 4'b0001,
    PH_FIELD_START = 4'b0010,
    PH_FIELD_MORE  = 4'b0100,
    PH_HALTED      = 4'b1000
  } phase_e;

  typedef enum logic [2:0] {
    F_END = 3'd0,
    F_VAL = 3'd1,
    F_SK1 = 3'd2,
    F_SK4 = 3'd3,
    F_TAB = 3'd4
  } field_e;

  typedef enum logic [1:0] {
    KIND_DONE    = 2'd0,
    KIND_CONT    = 2'd1,
    KIND_END     = 2'd2,
    KIND_UNKNOWN = 2'd3
  } kind_e;

  typedef field_e [0:PLAN_STEPS-1] plan_row_t;

  localparam plan_row_t EMPTY_ROW = '{default: F_END};

  localparam plan_row_t FIELD_PLAN [0:31] = '{
    EMPTY_ROW,
    '{F_VAL, F_END, F_END, F_END, F_END, F_END, F_END},
    '{F_VAL, F_SK4, F_END, F_END, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_SK4, F_END, F_END, F_END, F_END},
    '{F_VAL, F_SK4, F_END, F_END, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_VAL, F_SK4, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_SK4, F_END, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_SK4, F_END, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_VAL, F_SK4, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_VAL, F_VAL, F_SK4, F_END, F_END},
    '{F_VAL, F_SK4, F_END, F_END, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_SK4, F_END, F_END, F_END, F_END},
    '{F_SK4, F_VAL, F_VAL, F_SK4, F_END, F_END, F_END},
    '{F_VAL, F_SK4, F_END, F_END, F_END, F_END, F_END},
    EMPTY_ROW,
    '{F_VAL, F_VAL, F_VAL, F_TAB, F_END, F_END, F_END},
    '{F_VAL, F_VAL, F_SK4, F_VAL, F_SK4, F_END, F_END},
    '{F_VAL, F_VAL, F_SK1, F_VAL, F_VAL, F_SK4, F_END},
    '{F_VAL, F_SK1, F_VAL, F_VAL, F_SK4, F_END, F_END},
    '{F_VAL, F_SK4, F_END, F_END, F_END, F_END, F_END},
    EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW,
    EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW, EMPTY_ROW
  };

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  op;
    logic [2:0]  step;
    logic [1:0]  vbl;
    logic [31:0] skip;
    logic [31:0] acc;
    logic [31:0] tcount;
    logic [31:0] bcount;
  } state_t;

  typedef struct packed {
    kind_e       kind;
    logic [4:0]  opcode;
    logic [31:0] length;
    logic [31:0] disp;
  } result_t;

  function automatic field_e plan_at(logic [4:0] op, logic [2:0] step);
    field_e f;
    plan_row_t row;
    row = FIELD_PLAN[op];
    if (step > 3'(PLAN_STEPS - 1)) begin
      f = F_END;
    end else begin
      f = row[step];
    end
    return f;
  endfunction

endpackage

@@ rtl/uisp_step.sv @@
// Per-byte next-state and result logic of the cleanup program parser.
// Depends on uisp_pkg.
module uisp_step (
  input  uisp_pkg::state_t  st_i,
  input  logic [7:0]        byte_i,
  input  logic              restart_i,
  output uisp_pkg::state_t  st_o,
  output logic              emit_o,
  output uisp_pkg::result_t res_o
);

  uisp_pkg::phase_e ph;
  uisp_pkg::field_e f;
  logic [2:0]  step_n;
  logic [31:0] top;
  logic [31:0] sext;
  logic        done;
  logic        cont;

  always_comb begin
    st_o   = st_i;
    emit_o = 1'b0;
    res_o  = '{kind: uisp_pkg::KIND_DONE, opcode: '0, length: '0, disp: '0};
    done   = 1'b0;
    top    = '0;
    sext   = '0;
    step_n = st_i.step + 3'd1;
    cont   = (st_i.op == uisp_pkg::OPC_CONT);
    f      = uisp_pkg::plan_at(st_i.op, st_i.step);
    ph     = restart_i ? uisp_pkg::PH_OPCODE : st_i.phase;
    st_o.phase = ph;

    case (ph)
      uisp_pkg::PH_OPCODE: begin
        st_o.op     = byte_i[4:0] & uisp_pkg::OPC_MASK_W;
        st_o.step   = '0;
        st_o.vbl    = '0;
        st_o.skip   = '0;
        st_o.acc    = '0;
        st_o.bcount = 32'd1;
        res_o.opcode = byte_i[4:0];
        res_o.length = 32'd1;
        if (byte_i[7]) begin
          emit_o     = 1'b1;
          res_o.kind = uisp_pkg::KIND_END;
        end else if (uisp_pkg::plan_at(byte_i[4:0], 3'd0) == uisp_pkg::F_END) begin
          emit_o     = 1'b1;
          res_o.kind = uisp_pkg::KIND_UNKNOWN;
          st_o.phase = uisp_pkg::PH_HALTED;
        end else begin
          st_o.phase = uisp_pkg::PH_FIELD_START;
        end
      end
      uisp_pkg::PH_FIELD_START, uisp_pkg::PH_FIELD_MORE: begin
        if (st_i.bcount != '1) begin
          st_o.bcount = st_i.bcount + 32'd1;
        end
        if (ph == uisp_pkg::PH_FIELD_START) begin
          if (f == uisp_pkg::F_VAL) begin
            // Compact value: length from the low bits of the first byte.
            if (!byte_i[0]) begin
              top      = {25'd0, byte_i[7:1]};
              sext     = 32'hffff_ff80;
              st_o.vbl = 2'd0;
            end else if (!byte_i[1]) begin
              top      = {26'd0, byte_i[7:2]};
              sext     = 32'hffff_ffc0;
              st_o.vbl = 2'd1;
            end else begin
              top      = {27'd0, byte_i[7:3]};
              sext     = 32'hffff_ffe0;
              st_o.vbl = byte_i[2] ? 2'd3 : 2'd2;
            end
            st_o.acc = (cont && byte_i[7]) ? (top | sext) : top;
            done     = (st_o.vbl == 2'd0);
          end else begin
            case (f)
              uisp_pkg::F_SK1: st_o.skip = '0;
              uisp_pkg::F_TAB: st_o.skip = {st_i.tcount[29:0], 2'b00} + 32'd3;
              default:         st_o.skip = 32'd3;
            endcase
            done = (st_o.skip == '0);
          end
          if (!done) begin
            st_o.phase = uisp_pkg::PH_FIELD_MORE;
          end
        end else begin
          if (f == uisp_pkg::F_VAL) begin
            st_o.acc = {st_i.acc[23:0], byte_i};
            st_o.vbl = st_i.vbl - 2'd1;
            done     = (st_o.vbl == 2'd0);
          end else begin
            st_o.skip = st_i.skip - 32'd1;
            done      = (st_o.skip == '0);
          end
        end
        if (done) begin
          if (f == uisp_pkg::F_VAL && st_i.op == uisp_pkg::OPC_TABLE && st_i.step == 3'd0) begin
            st_o.tcount = st_o.acc;
          end
          st_o.step = step_n;
          if (uisp_pkg::plan_at(st_i.op, step_n) != uisp_pkg::F_END) begin
            st_o.phase = uisp_pkg::PH_FIELD_START;
          end else begin
            st_o.phase   = uisp_pkg::PH_OPCODE;
            emit_o       = 1'b1;
            res_o.kind   = cont ? uisp_pkg::KIND_CONT : uisp_pkg::KIND_DONE;
            res_o.opcode = st_i.op;
            res_o.length = st_o.bcount;
            res_o.disp   = cont ? st_o.acc : '0;
          end
        end
      end
      default: begin
        // halted: bytes are dropped until restart
      end
    endcase
  end

endmodule

@@ rtl/unwind_instruction_stream_parser_top.sv @@
// Top level of the cleanup program parser: input register, parser state, result register.
// Depends on uisp_pkg and uisp_step.

// Takes one byte of a compact cleanup program per transaction and reports each instruction
// boundary: kind (done, continuation, end of program, unknown opcode), opcode, length in bytes
// including the opcode byte (saturating at 32 bits) and, for continuation records, the signed
// decoded displacement. A byte with restart set starts a new instruction and drops any
// unfinished one; after an unknown opcode the parser drops every byte until a restart.
// Throughput is one byte per clock while the result register has room: the byte lands in
// an input register, and one pass of the per-byte step logic then updates the small parser
// counters and, when an instruction completes, loads the result register. out_valid_o
// therefore comes from the result register, which sits behind the input register that takes
// the byte that completes the instruction. While a finished result waits for out_ready_i,
// the input register still takes one more byte; in_ready_o then stays low until the result
// register drains, and a drain lets a new byte in at the same edge.
module unwind_instruction_stream_parser_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         in_byte_i,
  input  logic               restart_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic [4:0]         opcode_o,
  output logic [31:0]        length_o,
  output logic signed [31:0] displacement_o
);

  // input stage
  logic       in_vld_q, in_vld_d;
  logic [7:0] byte_q;
  logic       restart_q;

  // parser state and result stage
  uisp_pkg::state_t  st_q, st_d;
  uisp_pkg::state_t  st_step;
  uisp_pkg::result_t res_q, res_step;
  logic              out_vld_q, out_vld_d;
  logic              emit;
  logic              proc_go;

  // The step runs when a byte is held and the result register has room.
  assign proc_go    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || proc_go;

  uisp_step u_step (
    .st_i      (st_q),
    .byte_i    (byte_q),
    .restart_i (restart_q),
    .st_o      (st_step),
    .emit_o    (emit),
    .res_o     (res_step)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (proc_go) begin
      in_vld_d = 1'b0;
    end
  end

  assign st_d = proc_go ? st_step : st_q;

  always_comb begin
    out_vld_d = out_vld_q;
    if (proc_go && emit) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{phase: uisp_pkg::PH_OPCODE, op: '0, step: '0, vbl: '0,
                     skip: '0, acc: '0, tcount: '0, bcount: '0};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      st_q      <= st_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q    <= in_byte_i;
      restart_q <= restart_i;
    end
    if (proc_go && emit) begin
      res_q <= res_step;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign kind_o         = res_q.kind;
  assign opcode_o       = res_q.opcode;
  assign length_o       = res_q.length;
  assign displacement_o = $signed(res_q.disp);

endmodule

@@ rtl/uisp_checker.sv @@
// Port-level checks for the cleanup program parser, bound to the top level.
// Depends on uisp_pkg and unwind_instruction_stream_parser_top_macros.svh.
`include "unwind_instruction_stream_parser_top_macros.svh"

module uisp_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic [7:0]         in_byte_i,
  input logic               restart_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [1:0]         kind_o,
  input logic [4:0]         opcode_o,
  input logic [31:0]        length_o,
  input logic signed [31:0] displacement_o
);

  logic        in_stall;
  logic        out_stall;
  logic        short_kind;
  logic        body_kind;
  logic [8:0]  in_bus;
  logic [70:0] res_bus;

  assign in_stall   = in_valid_i && !in_ready_o;
  assign out_stall  = out_valid_o && !out_ready_i;
  assign short_kind = out_valid_o &&
                      (kind_o == uisp_pkg::KIND_END || kind_o == uisp_pkg::KIND_UNKNOWN);
  assign body_kind  = out_valid_o &&
                      (kind_o == uisp_pkg::KIND_DONE || kind_o == uisp_pkg::KIND_CONT);
  assign in_bus     = {in_byte_i, restart_i};
  assign res_bus    = {kind_o, opcode_o, length_o, displacement_o};

  // stalled input transaction holds
  `UISP_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_stall, in_valid_i && $stable(in_bus))

  // stalled result holds
  `UISP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, out_valid_o && $stable(res_bus))

  // single-byte kinds
  `UISP_ASSERT_IMP(a_short_len, clk_i, rst_ni, short_kind, length_o == 32'd1)

  // displacement only on continuation records
  `UISP_ASSERT_IMP(a_disp_zero, clk_i, rst_ni, out_valid_o && kind_o != uisp_pkg::KIND_CONT, displacement_o == 32'sd0)

  // a completed instruction spans its opcode byte and at least one field byte
  `UISP_ASSERT_IMP(a_done_len, clk_i, rst_ni, body_kind, length_o >= 32'd2 && opcode_o != 5'd0)

endmodule

bind unwind_instruction_stream_parser_top uisp_checker u_checker (.*);
